// ===== design/lsfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder package
// Shared types, register codes and byte helper functions.
// ----------------------------------------------------------------------------
package lsfe_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DRIVER = 2'd0;
    localparam logic [1:0] CFG_ORDER  = 2'd1;
    localparam logic [1:0] CFG_BRIGHT = 2'd2;

    // Driver codes.
    localparam logic [1:0] DRV_NONE = 2'd0;
    localparam logic [1:0] DRV_WS   = 2'd1;
    localparam logic [1:0] DRV_SK   = 2'd2;

    // Color order codes; the unused code falls back to the grey average.
    localparam logic [2:0] CO_GREY = 3'd0;
    localparam logic [2:0] CO_RGB  = 3'd1;
    localparam logic [2:0] CO_RBG  = 3'd2;
    localparam logic [2:0] CO_GRB  = 3'd3;
    localparam logic [2:0] CO_GBR  = 3'd4;
    localparam logic [2:0] CO_BRG  = 3'd5;
    localparam logic [2:0] CO_BGR  = 3'd6;

    // Raw brightness register codes.
    localparam logic [2:0] LVL_UNKNOWN = 3'd0;
    localparam logic [2:0] LVL_LOW     = 3'd1;
    localparam logic [2:0] LVL_MED     = 3'd2;
    localparam logic [2:0] LVL_HIGH    = 3'd3;
    localparam logic [2:0] LVL_FULL    = 3'd4;

    // Reciprocal of three in 11 fractional bits; exact for sums up to 765.
    localparam logic [19:0] GREY_RECIP = 20'd683;

    // Frame constants.
    localparam logic [7:0] HDR_MARK   = 8'hE0;
    localparam int         START_LEN  = 4;
    localparam int         RESET_LEN  = 4;
    localparam int         QUEUE_DEPTH = 2;

    // Normalized brightness carried with each queued pixel.
    typedef enum logic [1:0] {
        BR_LOW,
        BR_MED,
        BR_HIGH,
        BR_FULL
    } bright_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_HDR,
        ST_COLOR,
        ST_TAIL
    } back_state_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [1:0] driver;
        logic [2:0] order;
        logic [2:0] bright;
    } cfg_t;

    // One classified pixel waiting for the back end.
    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       ws;
        bright_t    br;
        logic       first;
        logic       last;
    } cmd_t;

    // Queue status seen by the back end.
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Three-byte mode scaling; nonzero values never drop below one.
    function automatic logic [7:0] ws_scale(input logic [7:0] v, input bright_t br);
        logic [7:0]  k;
        logic [7:0]  thr;
        logic [15:0] prod;
        logic [7:0]  res;
        unique case (br)
            BR_HIGH: begin k = 8'd200; thr = 8'd1; end
            BR_MED:  begin k = 8'd100; thr = 8'd2; end
            default: begin k = 8'd50;  thr = 8'd5; end
        endcase
        prod = 16'(v) * 16'(k);
        if (br == BR_FULL) begin
            res = v;
        end
        else if (v == 8'd0) begin
            res = 8'd0;
        end
        else if (v <= thr) begin
            res = 8'd1;
        end
        else begin
            res = prod[15:8];
        end
        return res;
    endfunction

    // Four-byte mode header byte.
    function automatic logic [7:0] sk_header(input bright_t br);
        logic [4:0] lvl;
        unique case (br)
            BR_FULL: lvl = 5'd31;
            BR_HIGH: lvl = 5'd20;
            BR_MED:  lvl = 5'd10;
            default: lvl = 5'd5;
        endcase
        return HDR_MARK | {3'b000, lvl};
    endfunction

endpackage

// ===== design/lsfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder front end
// Accepts pixels, applies the color order, tracks the strip position and
// pushes one command per pixel into the queue while a driver is set.
// ----------------------------------------------------------------------------
module lsfe_front #(
    parameter int LED_COUNT = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  lsfe_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic             q_full,
    output logic             push,
    output lsfe_pkg::cmd_t   push_cmd
);
    import lsfe_pkg::*;

    localparam logic [8:0] LAST_POS = 9'(LED_COUNT - 1);

    logic [7:0]  pos_reg;
    logic [7:0]  pos_next;
    logic        accept;
    logic        drop;
    logic        is_last;
    logic [9:0]  sum;
    logic [19:0] grey_prod;
    logic [7:0]  grey;
    bright_t     br;

    // Input transfer; pixels for no driver are taken and discarded.
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign drop     = (cfg.driver != DRV_WS) && (cfg.driver != DRV_SK);
    assign push     = accept && !drop;

    // Grey average through the reciprocal of three.
    assign sum       = 10'(red) + 10'(green) + 10'(blue);
    assign grey_prod = 20'(sum) * GREY_RECIP;
    assign grey      = grey_prod[18:11];

    assign is_last = {1'b0, pos_reg} >= LAST_POS;

    // Brightness normalization: unknown and unused codes act as low.
    always_comb
    begin
        unique case (cfg.bright)
            LVL_FULL: br = BR_FULL;
            LVL_HIGH: br = BR_HIGH;
            LVL_MED:  br = BR_MED;
            default:  br = BR_LOW;
        endcase
    end

    // Command assembly with the configured color order.
    always_comb
    begin
        push_cmd.ws    = (cfg.driver == DRV_WS);
        push_cmd.br    = br;
        push_cmd.first = (pos_reg == 8'd0);
        push_cmd.last  = is_last;
        unique case (cfg.order)
            CO_RGB:  begin push_cmd.c0 = red;   push_cmd.c1 = green; push_cmd.c2 = blue;  end
            CO_RBG:  begin push_cmd.c0 = red;   push_cmd.c1 = blue;  push_cmd.c2 = green; end
            CO_GRB:  begin push_cmd.c0 = green; push_cmd.c1 = red;   push_cmd.c2 = blue;  end
            CO_GBR:  begin push_cmd.c0 = green; push_cmd.c1 = blue;  push_cmd.c2 = red;   end
            CO_BRG:  begin push_cmd.c0 = blue;  push_cmd.c1 = red;   push_cmd.c2 = green; end
            CO_BGR:  begin push_cmd.c0 = blue;  push_cmd.c1 = green; push_cmd.c2 = red;   end
            default: begin push_cmd.c0 = grey;  push_cmd.c1 = grey;  push_cmd.c2 = grey;  end
        endcase
    end

    // Strip position advances on every pixel that is sent on.
    always_comb
    begin
        pos_next = pos_reg;
        if (push) begin
            pos_next = is_last ? 8'd0 : pos_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= 8'd0;
        end
        else begin
            pos_reg <= pos_next;
        end
    end

    // The position never runs past the last LED.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} <= LAST_POS)
        else $error("strip position beyond last LED");

    // A dropped pixel leaves the position alone.
    a_drop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && drop) |=> $stable(pos_reg))
        else $error("dropped pixel moved the position");

    // The last pixel wraps the position to zero.
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (push && is_last) |=> (pos_reg == 8'd0))
        else $error("position did not wrap after last pixel");

endmodule

// ===== design/lsfe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder command queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lsfe_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lsfe_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output lsfe_pkg::cmd_t      head,
    output lsfe_pkg::q_status_t status
);
    import lsfe_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign status.empty = (count_reg == CNT_W'(0));
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head         = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== design/lsfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder back end
// Expands queued pixels into the strip byte stream, one byte per cycle
// while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module lsfe_back #(
    parameter int LED_COUNT = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lsfe_pkg::cmd_t      head,
    input  lsfe_pkg::q_status_t q_status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                run_last,
    output logic                frame_end
);
    import lsfe_pkg::*;

    localparam int TAIL_LEN = RESET_LEN + LED_COUNT / 16 + 1;
    localparam int CNT_W    = $clog2(TAIL_LEN);

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic             valid_reg;
    logic             valid_next;
    logic [7:0]       byte_reg;
    logic             run_last_reg;
    logic             frame_end_reg;
    logic             out_free;
    logic             emit;
    logic             is_final;
    logic [7:0]       color;
    logic [7:0]       byte_val;
    back_state_t      load_state;

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

    assign out_free = !valid_reg || !out_stall;
    assign emit     = (state_reg != ST_IDLE) && out_free;

    // Color byte for the current slot.
    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    color = cmd_reg.c0;
            2'd1:    color = cmd_reg.c1;
            default: color = cmd_reg.c2;
        endcase
    end

    // Byte value and end-of-pixel flag for the current state.
    always_comb
    begin
        unique case (state_reg)
            ST_HDR:   byte_val = sk_header(cmd_reg.br);
            ST_COLOR: byte_val = cmd_reg.ws ? ws_scale(color, cmd_reg.br) : color;
            default:  byte_val = 8'd0;
        endcase
        if (!cmd_reg.ws && cmd_reg.last) begin
            is_final = (state_reg == ST_TAIL) && (cnt_reg == CNT_W'(TAIL_LEN - 1));
        end
        else begin
            is_final = (state_reg == ST_COLOR) && (cnt_reg == CNT_W'(2));
        end
    end

    // First state for the pixel at the head of the queue.
    always_comb
    begin
        if (head.ws) begin
            load_state = ST_COLOR;
        end
        else if (head.first) begin
            load_state = ST_START;
        end
        else begin
            load_state = ST_HDR;
        end
    end

    // Sequencer: next state and queue pop.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        pop        = !q_status.empty && ((state_reg == ST_IDLE) || (emit && is_final));
        if (pop) begin
            state_next = load_state;
            cnt_next   = '0;
            cmd_next   = head;
        end
        else if (emit && is_final) begin
            state_next = ST_IDLE;
            cnt_next   = '0;
        end
        else if (emit) begin
            unique case (state_reg)
                ST_START:
                begin
                    if (cnt_reg == CNT_W'(START_LEN - 1)) begin
                        state_next = ST_HDR;
                        cnt_next   = '0;
                    end
                    else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                ST_HDR:
                begin
                    state_next = ST_COLOR;
                    cnt_next   = '0;
                end
                ST_COLOR:
                begin
                    if (cnt_reg == CNT_W'(2)) begin
                        state_next = ST_TAIL;
                        cnt_next   = '0;
                    end
                    else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                ST_TAIL:
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // Output register holds a byte until its transfer.
    assign valid_next = out_free ? emit : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (emit) begin
            byte_reg      <= byte_val;
            run_last_reg  <= is_final;
            frame_end_reg <= is_final && cmd_reg.last;
        end
    end

    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && frame_end_reg) |-> run_last_reg)
        else $error("frame end without end of pixel");

    a_no_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !q_status.empty) |=> (state_reg != ST_IDLE))
        else $error("back end idle with queued pixel");

    a_color_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COLOR) |-> (cnt_reg <= CNT_W'(2)))
        else $error("color slot out of range");

    a_ws_no_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START || state_reg == ST_HDR || state_reg == ST_TAIL)
        |-> !cmd_reg.ws)
        else $error("frame bytes in three-byte mode");

endmodule

// ===== design/led_strip_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder core
// Turns RGB pixels into the byte stream of a three-byte or four-byte LED
// strip, with color ordering, brightness and start and end frames.
// ----------------------------------------------------------------------------
//
//   Port group   Direction  Handshake          Payload
//   pixel in     input      in_valid/in_stall  red, green, blue
//   byte out     output     out_valid/out_stall out_byte, run_last, frame_end
//   config       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// The back end sends one byte per cycle unless the output stalls: 3 bytes
// per pixel in three-byte mode and 4 in four-byte mode, which adds a 4-byte
// start frame on the first pixel and a 4 + LED_COUNT/16 + 1 byte end frame
// on the last. The output register and a two-entry command queue let pixels
// enter while earlier bytes still drain; a pixel reaching an idle back end
// passes the queue entry, command register and byte register before its
// first byte shows. Reset clears the control registers and the strip
// position. An output stall holds the byte register and, once the queue fills, stalls the input.
//
module led_strip_frame_encoder_core #(
    parameter int LED_COUNT = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       frame_end,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [2:0] cfg_data
);
    import lsfe_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      head;
    q_status_t q_status;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DRIVER: cfg_next.driver = cfg_data[1:0];
                CFG_ORDER:  cfg_next.order  = cfg_data;
                CFG_BRIGHT: cfg_next.bright = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '{driver: DRV_NONE, order: CO_GREY, bright: LVL_UNKNOWN};
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    lsfe_front #(
        .LED_COUNT (LED_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .q_full   (q_status.full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    lsfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    lsfe_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .frame_end (frame_end)
    );

endmodule
